@@ rtl/core/keyframe_channel_interpolator_top_macros.svh @@
// ----------------------------------------------------------------------------
// Keyframe channel interpolator: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_CHANNEL_INTERPOLATOR_TOP_MACROS_SVH
`define KEYFRAME_CHANNEL_INTERPOLATOR_TOP_MACROS_SVH

// Same-cycle implication
`define KCI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define KCI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/kci_pkg.sv @@
// ----------------------------------------------------------------------------
// Keyframe channel interpolator package
// Widths, mode codes and the sideband record carried down the pipeline.
// ----------------------------------------------------------------------------
package kci_pkg;

  localparam int ValW   = 16;  // channel value width
  localparam int TimeW  = 15;  // elapsed time / frame length width
  localparam int MagW   = 16;  // magnitude of the wrapped difference
  localparam int ProdW  = 30;  // |diff| * elapsed, always below 2^30
  localparam int QuoW   = 15;  // quotient is below |diff|, so below 2^15
  localparam int AngW   = 10;  // angle circle width

  // Divider: one quotient bit per step, three steps per stage
  localparam int StepsPerStage = 3;
  localparam int DivStages     = QuoW / StepsPerStage;

  localparam logic [AngW:0] AngleHalf = 11'h200;
  localparam logic [AngW+1:0] AngleFull = 12'h400;

  typedef enum logic [1:0] {
    MODE_ANGLE = 2'd0,
    MODE_STEP1 = 2'd1,
    MODE_STEP2 = 2'd2,
    MODE_BAD   = 2'd3
  } mode_t;

  // Per-item control and bypass data that rides beside the arithmetic
  typedef struct packed {
    logic            pass;        // result is pass_value, no interpolation
    logic            angle;       // wrap result to the angle circle
    logic            neg;         // difference was negative
    logic            done;        // elapsed reached frame length
    logic            bad;         // unsupported mode
    logic [ValW-1:0] base;        // value the scaled step is added to
    logic [ValW-1:0] pass_value;  // copied value when pass is set
  } side_t;

endpackage

@@ rtl/core/kci_if.sv @@
// ----------------------------------------------------------------------------
// Keyframe channel interpolator channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface kci_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           mode;
  logic signed [kci_pkg::ValW-1:0]      previous_value;
  logic signed [kci_pkg::ValW-1:0]      target_value;
  logic [kci_pkg::TimeW-1:0]            elapsed_time;
  logic [kci_pkg::TimeW-1:0]            frame_length;

  modport source (output valid, mode, previous_value, target_value, elapsed_time,
                  frame_length, input ready);
  modport sink (input valid, mode, previous_value, target_value, elapsed_time,
                frame_length, output ready);
endinterface

interface kci_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [kci_pkg::ValW-1:0]      channel_value;
  logic                                 frame_done;
  logic                                 bad_mode;

  modport source (output valid, channel_value, frame_done, bad_mode, input ready);
  modport sink (input valid, channel_value, frame_done, bad_mode, output ready);
endinterface

@@ rtl/core/keyframe_channel_interpolator_top.sv @@
// ----------------------------------------------------------------------------
// Keyframe channel interpolator, top level
// Interpolates one bone channel between two keyframe values.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one channel item per transfer: mode, previous and target
//   keyframe values, elapsed time and frame length. out_ch returns one
//   result per item, in order: channel_value, frame_done and bad_mode.
//   out_ch.valid rises once the item has passed eight register stages, the
//   first loaded at the transfer edge: two front end stages (difference,
//   then the 16 x 15 multiply), five divider stages of three quotient bits
//   each, and the output register.
//   Throughput is one item per cycle while out_ch.ready is not held low;
//   items are independent and may follow each other in every cycle.
//   Reset (rst, synchronous) clears all stage valid bits; the first item can
//   be sent in the cycle after reset is released.
//   When the receiver holds out_ch.ready low with a result waiting, the
//   whole pipeline freezes and in_ch.ready drops; nothing is lost or
//   repeated, and transfers resume as soon as the result is taken.
// ----------------------------------------------------------------------------
module keyframe_channel_interpolator_top (
  input  logic       clk,
  input  logic       rst,
  kci_in_if.sink     in_ch,
  kci_out_if.source  out_ch
);

  logic                          adv;
  logic                          prod_valid;
  logic [kci_pkg::ProdW-1:0]     prod;
  logic [kci_pkg::TimeW-1:0]     prod_len;
  kci_pkg::side_t                prod_side;
  logic                          quo_valid;
  logic [kci_pkg::QuoW-1:0]      quo;
  kci_pkg::side_t                quo_side;

  kci_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_ch      (in_ch),
    .prod_valid (prod_valid),
    .prod       (prod),
    .prod_len   (prod_len),
    .prod_side  (prod_side)
  );

  kci_div u_div (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .prod_valid (prod_valid),
    .prod       (prod),
    .prod_len   (prod_len),
    .prod_side  (prod_side),
    .quo_valid  (quo_valid),
    .quo        (quo),
    .quo_side   (quo_side)
  );

  kci_post u_post (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .quo_valid (quo_valid),
    .quo       (quo),
    .quo_side  (quo_side),
    .out_ch    (out_ch)
  );

endmodule

@@ rtl/core/kci_prep.sv @@
// ----------------------------------------------------------------------------
// Keyframe channel interpolator: front end
// Stage 1 wraps the difference and sorts out bypass cases, stage 2
// multiplies the difference magnitude by the elapsed time.
// ----------------------------------------------------------------------------
module kci_prep (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  kci_in_if.sink                        in_ch,
  output logic                          prod_valid,
  output logic [kci_pkg::ProdW-1:0]     prod,
  output logic [kci_pkg::TimeW-1:0]     prod_len,
  output kci_pkg::side_t                prod_side
);

  logic                          s1_valid;
  logic [kci_pkg::MagW-1:0]      s1_mag;
  logic [kci_pkg::TimeW-1:0]     s1_time;
  logic [kci_pkg::TimeW-1:0]     s1_len;
  kci_pkg::side_t                s1_side;

  kci_pkg::mode_t                mode;
  logic                          reached;
  logic [kci_pkg::AngW-1:0]      ang_a;
  logic [kci_pkg::AngW-1:0]      ang_b;
  logic signed [kci_pkg::AngW+1:0] ang_d;
  logic signed [kci_pkg::ValW-1:0] step_d;
  logic signed [kci_pkg::ValW:0] diff;
  logic [kci_pkg::ValW:0]        diff_abs;
  kci_pkg::side_t                side_next;
  logic [kci_pkg::ProdW:0]       prod_full;

  assign in_ch.ready = adv;

  // Difference on the angle circle or in 16-bit wrap arithmetic
  always_comb begin
    mode    = kci_pkg::mode_t'(in_ch.mode);
    reached = in_ch.elapsed_time >= in_ch.frame_length;
    ang_a   = in_ch.previous_value[kci_pkg::AngW-1:0];
    ang_b   = in_ch.target_value[kci_pkg::AngW-1:0];
    ang_d   = $signed({2'b00, ang_b}) - $signed({2'b00, ang_a});
    if (ang_d < -$signed({1'b0, kci_pkg::AngleHalf})) begin
      ang_d = ang_d + $signed(kci_pkg::AngleFull);
    end else if (ang_d > $signed({1'b0, kci_pkg::AngleHalf})) begin
      ang_d = ang_d - $signed(kci_pkg::AngleFull);
    end
    step_d = in_ch.target_value - in_ch.previous_value;
    diff   = (mode == kci_pkg::MODE_ANGLE) ? kci_pkg::ValW'(ang_d) + 17'sd0
                                           : {step_d[kci_pkg::ValW-1], step_d};
    if (mode == kci_pkg::MODE_ANGLE) begin
      diff = {{(kci_pkg::ValW - kci_pkg::AngW - 1){ang_d[kci_pkg::AngW+1]}}, ang_d};
    end
    diff_abs = diff[kci_pkg::ValW] ? (~diff + 17'd1) : diff;

    side_next.pass       = reached || (mode == kci_pkg::MODE_BAD);
    side_next.angle      = (mode == kci_pkg::MODE_ANGLE);
    side_next.neg        = diff[kci_pkg::ValW];
    side_next.done       = reached;
    side_next.bad        = (mode == kci_pkg::MODE_BAD);
    side_next.base       = (mode == kci_pkg::MODE_ANGLE)
                           ? {{(kci_pkg::ValW - kci_pkg::AngW){1'b0}}, ang_a}
                           : in_ch.previous_value;
    side_next.pass_value = reached ? in_ch.target_value : in_ch.previous_value;
  end

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_ch.valid;
    end
    if (adv) begin
      s1_mag  <= diff_abs[kci_pkg::MagW-1:0];
      s1_time <= in_ch.elapsed_time;
      s1_len  <= in_ch.frame_length;
      s1_side <= side_next;
    end
  end

  // Stage 2: one 16 x 15 multiply
  assign prod_full = {{(kci_pkg::ProdW + 1 - kci_pkg::MagW){1'b0}}, s1_mag} *
                     {{(kci_pkg::ProdW + 1 - kci_pkg::TimeW){1'b0}}, s1_time};

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (adv) begin
      prod_valid <= s1_valid;
    end
    if (adv) begin
      prod      <= prod_full[kci_pkg::ProdW-1:0];
      prod_len  <= s1_len;
      prod_side <= s1_side;
    end
  end

endmodule

@@ rtl/core/kci_div.sv @@
// ----------------------------------------------------------------------------
// Keyframe channel interpolator: pipelined divider
// Restoring division of the product by the frame length, three quotient
// bits per stage. A non-bypassed product's upper half is below the divisor.
// ----------------------------------------------------------------------------
`include "keyframe_channel_interpolator_top_macros.svh"

module kci_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          prod_valid,
  input  logic [kci_pkg::ProdW-1:0]     prod,
  input  logic [kci_pkg::TimeW-1:0]     prod_len,
  input  kci_pkg::side_t                prod_side,
  output logic                          quo_valid,
  output logic [kci_pkg::QuoW-1:0]      quo,
  output kci_pkg::side_t                quo_side
);

  localparam int NS = kci_pkg::DivStages;

  logic                       vld    [NS];
  logic [kci_pkg::TimeW-1:0]  rem    [NS];
  logic [kci_pkg::QuoW-1:0]   low    [NS];
  logic [kci_pkg::QuoW-1:0]   q      [NS];
  logic [kci_pkg::TimeW-1:0]  den    [NS];
  kci_pkg::side_t             side   [NS];

  logic                       src_vld  [NS];
  logic [kci_pkg::TimeW-1:0]  src_rem  [NS];
  logic [kci_pkg::QuoW-1:0]   src_low  [NS];
  logic [kci_pkg::QuoW-1:0]   src_q    [NS];
  logic [kci_pkg::TimeW-1:0]  src_den  [NS];
  kci_pkg::side_t             src_side [NS];

  // Stage 0 starts from the product split into halves
  assign src_vld[0]  = prod_valid;
  assign src_rem[0]  = prod[kci_pkg::ProdW-1:kci_pkg::QuoW];
  assign src_low[0]  = prod[kci_pkg::QuoW-1:0];
  assign src_q[0]    = '0;
  assign src_den[0]  = prod_len;
  assign src_side[0] = prod_side;

  for (genvar s = 1; s < NS; s++) begin : g_link
    assign src_vld[s]  = vld[s-1];
    assign src_rem[s]  = rem[s-1];
    assign src_low[s]  = low[s-1];
    assign src_q[s]    = q[s-1];
    assign src_den[s]  = den[s-1];
    assign src_side[s] = side[s-1];
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [kci_pkg::TimeW-1:0] rem_next;
    logic [kci_pkg::QuoW-1:0]  low_next;
    logic [kci_pkg::QuoW-1:0]  q_next;

    // Shift in one dividend bit per step, subtract when it fits
    always_comb begin
      logic [kci_pkg::TimeW:0] trial;
      rem_next = src_rem[s];
      low_next = src_low[s];
      q_next   = src_q[s];
      for (int k = 0; k < kci_pkg::StepsPerStage; k++) begin
        trial    = {rem_next, low_next[kci_pkg::QuoW-1]};
        low_next = {low_next[kci_pkg::QuoW-2:0], 1'b0};
        if (trial >= {1'b0, src_den[s]}) begin
          trial  = trial - {1'b0, src_den[s]};
          q_next = {q_next[kci_pkg::QuoW-2:0], 1'b1};
        end else begin
          q_next = {q_next[kci_pkg::QuoW-2:0], 1'b0};
        end
        rem_next = trial[kci_pkg::TimeW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (adv) begin
        vld[s] <= src_vld[s];
      end
      if (adv) begin
        rem[s]  <= rem_next;
        low[s]  <= low_next;
        q[s]    <= q_next;
        den[s]  <= src_den[s];
        side[s] <= src_side[s];
      end
    end
  end

  assign quo_valid = vld[NS-1];
  assign quo       = q[NS-1];
  assign quo_side  = side[NS-1];

  `KCI_ASSERT_NOW(a_div_start_fits, prod_valid && !prod_side.pass,
    prod[kci_pkg::ProdW-1:kci_pkg::QuoW] < prod_len, "product upper half not below length")
  `KCI_ASSERT_NOW(a_div_rem_below, vld[NS-1] && !side[NS-1].pass,
    rem[NS-1] < den[NS-1], "final remainder not below divisor")

endmodule

@@ rtl/core/kci_post.sv @@
// ----------------------------------------------------------------------------
// Keyframe channel interpolator: back end
// Applies the sign to the quotient, adds the base value, wraps angles and
// holds the result (or the bypass value) in the output register.
// ----------------------------------------------------------------------------
`include "keyframe_channel_interpolator_top_macros.svh"

module kci_post (
  input  logic                          clk,
  input  logic                          rst,
  output logic                          adv,
  input  logic                          quo_valid,
  input  logic [kci_pkg::QuoW-1:0]      quo,
  input  kci_pkg::side_t                quo_side,
  kci_out_if.source                     out_ch
);

  logic [kci_pkg::ValW-1:0] q_ext;
  logic [kci_pkg::ValW-1:0] delta;
  logic [kci_pkg::ValW-1:0] sum;
  logic [kci_pkg::ValW-1:0] value_next;

  // Whole pipeline moves when the output register is free or being taken
  assign adv = !out_ch.valid || out_ch.ready;

  always_comb begin
    q_ext = {{(kci_pkg::ValW - kci_pkg::QuoW){1'b0}}, quo};
    delta = quo_side.neg ? (~q_ext + 16'd1) : q_ext;
    sum   = quo_side.base + delta;
    if (quo_side.pass) begin
      value_next = quo_side.pass_value;
    end else if (quo_side.angle) begin
      value_next = {{(kci_pkg::ValW - kci_pkg::AngW){1'b0}}, sum[kci_pkg::AngW-1:0]};
    end else begin
      value_next = sum;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      out_ch.valid <= quo_valid;
    end
    if (adv) begin
      out_ch.channel_value <= value_next;
      out_ch.frame_done    <= quo_side.done;
      out_ch.bad_mode      <= quo_side.bad;
    end
  end

  `KCI_ASSERT_NOW(a_post_angle_step, quo_valid && !quo_side.pass && quo_side.angle,
    quo <= 15'd512, "angle step exceeds half circle")
  `KCI_ASSERT_NOW(a_post_pass_cause, quo_valid && quo_side.pass && !quo_side.done,
    quo_side.bad, "bypass without frame reached or bad mode")

endmodule

@@ test/keyframe_channel_interpolator_top_tb.sv @@
// ----------------------------------------------------------------------------
// Keyframe channel interpolator testbench
// Streams bone channel items into the interpolator through its valid/ready
// input channel and checks every result against a built-in predictor or a
// typed-in value. A short table of hand-picked cases comes first: zero and
// full frame lengths, angle wrap at half a turn, 16-bit step wrap and the
// unsupported mode. Random keyframe sweeps and loose noise items follow,
// with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module keyframe_channel_interpolator_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ValW  = kci_pkg::ValW;
  localparam int TimeW = kci_pkg::TimeW;
  localparam int AngW  = kci_pkg::AngW;

  localparam int NumDirected  = 22;
  localparam int RandomItems  = 650;
  localparam int IdlePercent  = 14;
  localparam int MaxTimeUnits = 5_000_000;  // run time limit, in ns

  typedef struct packed {
    kci_pkg::mode_t         mode;
    logic signed [ValW-1:0] previous;
    logic signed [ValW-1:0] target;
    logic [TimeW-1:0]       elapsed;
    logic [TimeW-1:0]       length;
  } channel_item_t;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic            done;
    logic            bad;
  } channel_result_t;

  typedef struct packed {
    channel_item_t   item;
    logic            fixed;  // use the typed-in result below
    channel_result_t want;
  } directed_case_t;

  logic clk;
  logic rst;
  logic no_idle;

  kci_in_if  in_ch();
  kci_out_if out_ch();

  channel_result_t pending_results[$];

  int errors;
  int results_checked;
  int items_sent;
  int angle_items;
  int step_items;
  int bad_items;
  int frame_end_items;

  keyframe_channel_interpolator_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Hand-picked items; the first eight have results readable at a glance
  directed_case_t directed_cases [NumDirected] = '{
    // zero-length frame copies the unmasked target
    '{'{kci_pkg::MODE_ANGLE, 16'h1234, 16'hFFFF, 15'h0000, 15'h0000},
      1'b1, '{16'hFFFF, 1'b1, 1'b0}},
    // zero-length frame in the unsupported mode still copies
    '{'{kci_pkg::MODE_BAD,   16'h0001, 16'h8000, 15'h0000, 15'h0000},
      1'b1, '{16'h8000, 1'b1, 1'b1}},
    // elapsed equals the longest frame
    '{'{kci_pkg::MODE_STEP1, 16'h8000, 16'h7FFF, 15'h7FFF, 15'h7FFF},
      1'b1, '{16'h7FFF, 1'b1, 1'b0}},
    // elapsed past the frame
    '{'{kci_pkg::MODE_STEP2, 16'h0000, 16'h4321, 15'h7FFF, 15'h0001},
      1'b1, '{16'h4321, 1'b1, 1'b0}},
    // unsupported mode mid-frame holds the previous value
    '{'{kci_pkg::MODE_BAD,   16'hBEEF, 16'h1234, 15'h0000, 15'h7FFF},
      1'b1, '{16'hBEEF, 1'b0, 1'b1}},
    '{'{kci_pkg::MODE_BAD,   16'h7FFF, 16'h0000, 15'h7FFE, 15'h7FFF},
      1'b1, '{16'h7FFF, 1'b0, 1'b1}},
    // zero weight: angle comes out masked
    '{'{kci_pkg::MODE_ANGLE, 16'hFC05, 16'h0007, 15'h0000, 15'h0005},
      1'b1, '{16'h0005, 1'b0, 1'b0}},
    '{'{kci_pkg::MODE_STEP1, 16'h1234, 16'h5678, 15'h0000, 15'd100},
      1'b1, '{16'h1234, 1'b0, 1'b0}},
    // angle: short way round in both directions
    '{'{kci_pkg::MODE_ANGLE, 16'd1000, 16'd10,   15'd1,    15'd2},    1'b0, '0},
    '{'{kci_pkg::MODE_ANGLE, 16'd10,   16'd1000, 15'd1,    15'd2},    1'b0, '0},
    // angle: difference of exactly plus and minus half a turn
    '{'{kci_pkg::MODE_ANGLE, 16'h0000, 16'h0200, 15'd1,    15'd2},    1'b0, '0},
    '{'{kci_pkg::MODE_ANGLE, 16'h0200, 16'h0000, 15'd1,    15'd2},    1'b0, '0},
    // angle: just past half a turn wraps
    '{'{kci_pkg::MODE_ANGLE, 16'h0000, 16'h0201, 15'd1,    15'd3},    1'b0, '0},
    // angle: negative quotient truncates toward zero
    '{'{kci_pkg::MODE_ANGLE, 16'h0003, 16'h0000, 15'd1,    15'd2},    1'b0, '0},
    '{'{kci_pkg::MODE_ANGLE, 16'hFFFF, 16'h8000, 15'h7FFE, 15'h7FFF}, 1'b0, '0},
    '{'{kci_pkg::MODE_ANGLE, 16'h0200, 16'h0600, 15'd5,    15'h7FFF}, 1'b0, '0},
    // step: difference wraps through the sign boundary
    '{'{kci_pkg::MODE_STEP1, 16'h7FFF, 16'h8000, 15'd1,    15'd2},    1'b0, '0},
    '{'{kci_pkg::MODE_STEP1, 16'h8000, 16'h7FFF, 15'h7FFE, 15'h7FFF}, 1'b0, '0},
    '{'{kci_pkg::MODE_STEP2, 16'h0000, 16'h8000, 15'h7FFE, 15'h7FFF}, 1'b0, '0},
    '{'{kci_pkg::MODE_STEP2, 16'h8000, 16'h0000, 15'h4000, 15'h7FFF}, 1'b0, '0},
    '{'{kci_pkg::MODE_STEP1, 16'hC000, 16'h3FFF, 15'd3,    15'd7},    1'b0, '0},
    '{'{kci_pkg::MODE_STEP2, 16'h7000, 16'h9000, 15'h7FFE, 15'h7FFF}, 1'b0, '0}
  };

  // Expected output for one channel item
  function automatic channel_result_t interpolate_channel(channel_item_t it);
    channel_result_t r;
    logic [ValW-1:0] diff16;
    int              a;
    int              b;
    int              d;
    int              q;
    int              sum;
    r.bad  = (it.mode == kci_pkg::MODE_BAD);
    r.done = 1'b0;
    if (it.elapsed >= it.length) begin
      r.value = it.target;
      r.done  = 1'b1;
    end else if (it.mode == kci_pkg::MODE_ANGLE) begin
      a = int'(it.previous[AngW-1:0]);
      b = int'(it.target[AngW-1:0]);
      d = b - a;
      // take the shorter way round the circle
      if (d < -int'(kci_pkg::AngleHalf)) begin
        d = d + int'(kci_pkg::AngleFull);
      end else if (d > int'(kci_pkg::AngleHalf)) begin
        d = d - int'(kci_pkg::AngleFull);
      end
      q = (d * int'(it.elapsed)) / int'(it.length);
      sum = a + q;
      r.value = '0;
      r.value[AngW-1:0] = sum[AngW-1:0];
    end else if (it.mode == kci_pkg::MODE_STEP1 || it.mode == kci_pkg::MODE_STEP2) begin
      diff16 = it.target - it.previous;
      d = int'($signed(diff16));
      q = (d * int'(it.elapsed)) / int'(it.length);
      r.value = it.previous + q[ValW-1:0];
    end else begin
      r.value = it.previous;
    end
    return r;
  endfunction

  // Channel values: mostly anything, sometimes a boundary pattern
  function automatic logic [ValW-1:0] pick_value();
    logic [ValW-1:0] v;
    if ($urandom_range(99) < 75) begin
      v = ValW'($urandom);
    end else begin
      case ($urandom_range(5))
        0:       v = 16'h0000;
        1:       v = 16'h7FFF;
        2:       v = 16'h8000;
        3:       v = 16'hFFFF;
        4:       v = 16'h03FF;
        default: v = 16'h0200;
      endcase
    end
    return v;
  endfunction

  function automatic kci_pkg::mode_t pick_mode();
    int r;
    r = $urandom_range(99);
    if (r < 45) return kci_pkg::MODE_ANGLE;
    if (r < 70) return kci_pkg::MODE_STEP1;
    if (r < 92) return kci_pkg::MODE_STEP2;
    return kci_pkg::MODE_BAD;
  endfunction

  // Frame lengths: mostly short keyframes, some long, a few extremes
  function automatic logic [TimeW-1:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 60) return TimeW'($urandom_range(64, 1));
    if (r < 88) return TimeW'($urandom_range(32767, 1));
    if (r < 96) return 15'h7FFF;
    return 15'h0000;
  endfunction

  // Drive one item and record its expected result on the transfer
  task automatic send_item(channel_item_t it, logic fixed, channel_result_t want);
    while (!no_idle && $urandom_range(99) < IdlePercent) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.mode           <= it.mode;
    in_ch.previous_value <= it.previous;
    in_ch.target_value   <= it.target;
    in_ch.elapsed_time   <= it.elapsed;
    in_ch.frame_length   <= it.length;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(fixed ? want : interpolate_channel(it));
    items_sent++;
    if (it.elapsed >= it.length) frame_end_items++;
    if (it.mode == kci_pkg::MODE_ANGLE) begin
      angle_items++;
    end else if (it.mode == kci_pkg::MODE_BAD) begin
      bad_items++;
    end else begin
      step_items++;
    end
  endtask

  // Hold the sender off until the pipeline has emptied
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Compare one result transfer with the oldest expectation
  task automatic check_result();
    channel_result_t want;
    if (pending_results.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("unexpected result: value %h done %b bad %b",
                 out_ch.channel_value, out_ch.frame_done, out_ch.bad_mode);
      end
    end else begin
      want = pending_results.pop_front();
      results_checked++;
      if (out_ch.channel_value !== want.value || out_ch.frame_done !== want.done ||
          out_ch.bad_mode !== want.bad) begin
        errors++;
        if (errors <= 10) begin
          $display("result %0d mismatch: value %h/%h done %b/%b bad %b/%b (exp/got)",
                   results_checked, want.value, out_ch.channel_value, want.done,
                   out_ch.frame_done, want.bad, out_ch.bad_mode);
        end
      end
    end
  endtask

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Result side: check transfers, then pick ready for the next cycle
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) check_result();
    out_ch.ready <= no_idle || ($urandom_range(99) >= IdlePercent);
  end

  // Run time limit
  initial begin
    #(MaxTimeUnits);
    $display("FAIL keyframe_channel_interpolator_top");
    $finish;
  end

  // Stimulus
  initial begin
    channel_item_t it;
    int            random_sent;
    int            e;
    int            stride;
    int            sweep_len;
    bit            paused;

    rst                  = 1'b1;
    no_idle              = 1'b0;
    out_ch.ready         = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.mode           = kci_pkg::MODE_ANGLE;
    in_ch.previous_value = '0;
    in_ch.target_value   = '0;
    in_ch.elapsed_time   = '0;
    in_ch.frame_length   = '0;
    errors               = 0;
    results_checked      = 0;
    items_sent           = 0;
    angle_items          = 0;
    step_items           = 0;
    bad_items            = 0;
    frame_end_items      = 0;
    random_sent          = 0;
    paused               = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    for (int i = 0; i < NumDirected; i++) begin
      send_item(directed_cases[i].item, directed_cases[i].fixed, directed_cases[i].want);
    end
    drain_results();

    // Random part: keyframe sweeps with some loose noise items
    while (random_sent < RandomItems) begin
      no_idle <= (random_sent >= 200 && random_sent < 330);
      if (!paused && random_sent >= 400) begin
        drain_results();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 20) begin
        it.mode     = kci_pkg::mode_t'($urandom_range(3));
        it.previous = ValW'($urandom);
        it.target   = ValW'($urandom);
        it.length   = TimeW'($urandom);
        it.elapsed  = TimeW'($urandom);
        send_item(it, 1'b0, '0);
        random_sent++;
      end else begin
        // one channel played from the start of a keyframe to its end, or for up to 24 items
        it.mode     = pick_mode();
        it.previous = pick_value();
        it.target   = pick_value();
        it.length   = pick_length();
        stride      = int'(it.length) / $urandom_range(8, 2);
        if (stride < 1) stride = 1;
        e           = 0;
        sweep_len   = 0;
        do begin
          it.elapsed = (e > 32767) ? 15'h7FFF : TimeW'(e);
          send_item(it, 1'b0, '0);
          random_sent++;
          sweep_len++;
          e = e + $urandom_range(stride, 1);
        end while (int'(it.elapsed) < int'(it.length) && sweep_len < 24);
      end
    end
    in_ch.valid <= 1'b0;
    no_idle     <= 1'b0;

    // Wait for the tail, then a little longer for anything extra
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d channel items (%0d from the table): %0d angle, %0d step,",
             items_sent, NumDirected, angle_items, step_items);
    $display("  %0d unsupported mode, %0d at or past frame end; %0d results checked",
             bad_items, frame_end_items, results_checked);
    if (errors == 0) begin
      $display("PASS keyframe_channel_interpolator_top");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL keyframe_channel_interpolator_top");
    end
    $finish;
  end

endmodule
